// ===== src/dash_pkg.sv =====
`default_nettype none

package dash_pkg;

    // Sizing
    localparam int NUM_TEST      = 8;
    localparam int NUM_ANCESTRAL = 4;
    localparam int NUM_SAMPLED   = 4;
    localparam int COUNT_WIDTH   = 32;

    // Lanes carried by the input fields
    localparam int ANC_LANES  = 4;
    localparam int TEST_LANES = 8;
    localparam int OUT_W      = 32;

    localparam int SAMPLE_W   = $clog2(NUM_SAMPLED);
    localparam int ADDR_W     = SAMPLE_W + NUM_TEST;
    localparam int DEPTH      = NUM_SAMPLED * (2 ** NUM_TEST);
    localparam int ENTRY_W    = 2 * COUNT_WIDTH;

    // Base codes
    localparam logic [2:0] BASE_MISSING = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_COUNTED   = 2'd0;
    localparam logic [1:0] STAT_ANC_BAD   = 2'd1;
    localparam logic [1:0] STAT_SMP_MISS  = 2'd2;
    localparam logic [1:0] STAT_READ_DATA = 2'd3;

    // Opcodes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Config register indexes
    localparam logic REG_ANC_USED  = 1'b0;
    localparam logic REG_TEST_USED = 1'b1;

    typedef logic [NUM_TEST-1:0]    t_mask;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_READ,
        S_UPDATE,
        S_DONE
    } t_state;

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

endpackage

`default_nettype wire

// ===== src/dash_ram.sv =====
`default_nettype none

module dash_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/derived_allele_share_histogram.sv =====
`default_nettype none

// Derived-allele share histogram. Count requests (opcode 0) carry one site:
// the ancestral lanes settle a single ancestral base, the test lanes form one
// combination mask per nucleotide, and every nonempty mask of a derived base
// bumps the informative counter of (sample_index, mask), plus the shared
// counter when the sampled base is that base. Read requests (opcode 1) return
// both counters of (sample_index, combination). Counters saturate. All
// counters sit in one memory of 1024 x 64 bits with one read port and one
// write port (informative in the low half, shared in the high half); after
// reset a clearing pass writes zero to every entry, during which o_in_ready
// stays low (config writes are taken throughout). A counted site visits the
// nucleotides in order: one whose mask is empty or ancestral is passed over,
// one that is updated is read, then written back; then the result is handed
// off. Skipped sites (missing sampled base, bad ancestral) go straight to the
// hand-off, and reads fetch the entry first. A finished result sits in an
// output register, so a new request is taken while it waits to be collected.

module derived_allele_share_histogram
    import dash_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [1:0]  i_sample_index,
    input  wire logic [2:0]  i_sampled_base,
    input  wire logic [11:0] i_ancestral_bases,
    input  wire logic [23:0] i_test_bases,
    input  wire logic [7:0]  i_combination,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_informative_count,
    output logic [31:0]      o_shared_count
);

    // Sequencer
    t_state r_state, n_state;
    logic [1:0]          r_k;
    logic [ADDR_W-1:0]   r_clr_addr;

    // Config registers
    logic [2:0] r_anc_used;
    logic [3:0] r_test_used;

    // Request held during processing
    logic [SAMPLE_W-1:0] r_who;
    logic                r_is_read;
    logic [1:0]          r_status;
    logic [2:0]          r_anc;
    logic [2:0]          r_sbase;
    t_mask               r_mask [4];
    t_mask               r_comb;

    // Output register
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_inf;
    logic [31:0] r_out_sh;

    // Site decode from input fields
    logic       c_settled;
    logic       c_anc_bad;
    logic [2:0] c_anc;
    logic [2:0] c_code;
    logic [1:0] c_status;
    t_mask      c_mask [4];

    // Memory port
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

    logic   k_skip;
    logic   in_acc;
    logic   out_free;
    t_count cur_inf, cur_sh;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Ancestral settling and per-base test masks
    always_comb begin
        c_settled = 1'b0;
        c_anc_bad = 1'b0;
        c_anc     = '0;
        c_code    = '0;
        for (int m = 0; m < 4; m++) begin
            c_mask[m] = '0;
        end
        for (int j = 0; j < ANC_LANES; j++) begin
            if (j < NUM_ANCESTRAL && 3'(j) < r_anc_used) begin
                c_code = i_ancestral_bases[3*j +: 3];
                if (!c_settled) begin
                    if (c_code != BASE_MISSING) begin
                        c_anc     = c_code;
                        c_settled = 1'b1;
                    end
                end else if (c_code != c_anc) begin
                    c_anc_bad = 1'b1;
                end
            end
        end
        for (int j = 0; j < TEST_LANES; j++) begin
            if (j < NUM_TEST && 4'(j) < r_test_used) begin
                c_code = i_test_bases[3*j +: 3];
                if (!c_code[2]) begin
                    c_mask[c_code[1:0]][j] = 1'b1;
                end
            end
        end
        if (i_sampled_base == BASE_MISSING) begin
            c_status = STAT_SMP_MISS;
        end else if (!c_settled || c_anc_bad) begin
            c_status = STAT_ANC_BAD;
        end else begin
            c_status = STAT_COUNTED;
        end
    end

    // A base is passed over when its mask is empty or it is the ancestral one
    assign k_skip  = (r_mask[r_k] == '0) || (r_anc == {1'b0, r_k});
    assign cur_inf = ram_rdata[COUNT_WIDTH-1:0];
    assign cur_sh  = ram_rdata[ENTRY_W-1:COUNT_WIDTH];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_READ) begin
                        n_state = S_FETCH;
                    end else if (c_status == STAT_COUNTED) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: n_state = S_DONE;
            S_READ: begin
                if (!k_skip) begin
                    n_state = S_UPDATE;
                end else if (r_k == 2'd3) begin
                    n_state = S_DONE;
                end
            end
            S_UPDATE: n_state = (r_k == 2'd3) ? S_DONE : S_READ;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Memory controls
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = {r_who, r_mask[r_k]};
        ram_raddr = {r_who, r_mask[r_k]};
        ram_wdata = {(r_sbase == {1'b0, r_k}) ? sat_inc(cur_sh) : cur_sh,
                     sat_inc(cur_inf)};
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = {r_who, r_comb};
            end
            S_READ: begin
                ram_re = !k_skip;
            end
            S_UPDATE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    dash_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_anc_used  <= 3'd1;
            r_test_used <= 4'd8;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (in_acc) begin
                r_k <= '0;
            end else if ((r_state == S_READ && k_skip) || r_state == S_UPDATE) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ANC_USED) begin
                    r_anc_used <= i_cfg_data[2:0];
                end else begin
                    r_test_used <= i_cfg_data;
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_who     <= i_sample_index[SAMPLE_W-1:0];
            r_is_read <= (i_opcode == OP_READ);
            r_status  <= (i_opcode == OP_READ) ? STAT_READ_DATA : c_status;
            r_anc     <= c_anc;
            r_sbase   <= i_sampled_base;
            r_comb    <= i_combination[NUM_TEST-1:0];
            for (int m = 0; m < 4; m++) begin
                r_mask[m] <= c_mask[m];
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_inf    <= r_is_read ? OUT_W'(cur_inf) : '0;
            r_out_sh     <= r_is_read ? OUT_W'(cur_sh) : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_informative_count = r_out_inf;
    assign o_shared_count      = r_out_sh;

endmodule

`default_nettype wire

// ===== src/dash_chk.sv =====
`default_nettype none

module dash_chk
    import dash_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_informative_count,
    input wire logic [31:0] o_shared_count
);

    // Result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // One request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    // Only reads carry counter values
    a_zero_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_READ_DATA
            |-> o_informative_count == '0 && o_shared_count == '0)
        else $error("counter data on a non-read result");

    // Shared is only bumped together with informative
    a_shared_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STAT_READ_DATA
            |-> o_shared_count <= o_informative_count)
        else $error("shared count above informative count");

endmodule

bind derived_allele_share_histogram dash_chk u_dash_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_status            (o_status),
    .o_informative_count (o_informative_count),
    .o_shared_count      (o_shared_count)
);

`default_nettype wire
